[rtl/bbpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helper functions for the battery, button and
// charger status monitor. No dependencies.
package bbpm_pkg;

  // Field widths of the sample and report items.
  localparam int BATT_ADC_W = 11;
  localparam int BTN_ADC_W  = 11;
  localparam int STAT_ADC_W = 12;
  localparam int MV_W       = 13;
  localparam int TICKS_W    = 16;

  // Default ring depth for the battery average.
  localparam int DEFAULT_AVERAGE_DEPTH = 8;

  // Divider scale 5.02 in Q8.8: multiply by 1285, then shift right by 8.
  localparam int SCALE_NUM   = 1285;
  localparam int SCALE_NUM_W = 11;
  localparam int SCALE_SHIFT = 8;

  // Charger status decode thresholds in millivolts.
  localparam int STAT_IDLE_MV     = 2500;
  localparam int STAT_COMPLETE_MV = 1850;
  localparam int STAT_CHARGING_MV = 1450;

  // Register reset values.
  localparam logic [MV_W-1:0]    LOW_BATTERY_MV_RST      = MV_W'(3400);
  localparam logic [TICKS_W-1:0] LOW_BATTERY_TICKS_RST   = TICKS_W'(100);
  localparam logic [TICKS_W-1:0] LONG_PRESS_TICKS_RST    = TICKS_W'(50);
  localparam logic [MV_W-1:0]    BUTTON_THRESHOLD_MV_RST = MV_W'(2000);

  // Configuration port geometry.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOW_BATTERY_MV      = 3'd0,
    REG_LOW_BATTERY_TICKS   = 3'd1,
    REG_LONG_PRESS_TICKS    = 3'd2,
    REG_SHUTDOWN_ON_LONG    = 3'd3,
    REG_BUTTON_ENABLED      = 3'd4,
    REG_STATUS_ENABLED      = 3'd5,
    REG_BUTTON_THRESHOLD_MV = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    CHG_IDLE   = 2'd0,
    CHG_FULL   = 2'd1,
    CHG_ACTIVE = 2'd2,
    CHG_ERROR  = 2'd3
  } charge_t;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_IDLE  = 2'd1,
    MODE_SHORT = 2'd2,
    MODE_LONG  = 2'd3
  } press_mode_t;

  // Map the status pin voltage onto a charge state.
  function automatic charge_t decode_status(input logic [STAT_ADC_W-1:0] mv);
    charge_t state;
    if (mv > STAT_ADC_W'(STAT_IDLE_MV)) begin
      state = CHG_IDLE;
    end else if (mv > STAT_ADC_W'(STAT_COMPLETE_MV)) begin
      state = CHG_FULL;
    end else if (mv > STAT_ADC_W'(STAT_CHARGING_MV)) begin
      state = CHG_ACTIVE;
    end else begin
      state = CHG_ERROR;
    end
    return state;
  endfunction

endpackage
`default_nettype wire

[rtl/bbpm_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel carrying one sample item of three converter readings.
// Depends on bbpm_pkg for the field widths.
interface bbpm_in_if;
  import bbpm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [BATT_ADC_W-1:0] battery_adc_mv;
  logic [BTN_ADC_W-1:0]  button_adc_mv;
  logic [STAT_ADC_W-1:0] status_adc_mv;

  modport source (
    output valid, battery_adc_mv, button_adc_mv, status_adc_mv,
    input  ready
  );

  modport sink (
    input  valid, battery_adc_mv, button_adc_mv, status_adc_mv,
    output ready
  );
endinterface
`default_nettype wire

[rtl/bbpm_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel carrying one report item per processed sample.
// Depends on bbpm_pkg for the field widths and the charge state type.
interface bbpm_out_if;
  import bbpm_pkg::*;

  logic            valid;
  logic            ready;
  logic [MV_W-1:0] battery_mv;
  logic            button_is_down;
  logic            short_press_pulse;
  logic            long_press_pulse;
  charge_t         charge_status;
  logic            power_hold;

  modport source (
    output valid, battery_mv, button_is_down, short_press_pulse, long_press_pulse,
           charge_status, power_hold,
    input  ready
  );

  modport sink (
    input  valid, battery_mv, button_is_down, short_press_pulse, long_press_pulse,
           charge_status, power_hold,
    output ready
  );
endinterface
`default_nettype wire

[rtl/battery_button_power_monitor.sv]
// Throughput: one item per cycle unless the report side stalls; a five-register
// pipeline (input, sum, scale, divide, report) with per-stage valid bits lets
// bubbles absorb output stalls.
// Reset (rst, synchronous) empties the pipeline, restores register defaults,
// raises power_hold and waits for the first item to prime the battery average.
`timescale 1ns / 1ps
`default_nettype none
// Top level of the battery, button and charger status monitor.
// Depends on bbpm_pkg, bbpm_in_if and bbpm_out_if.
module battery_button_power_monitor #(
  parameter int AVERAGE_DEPTH = bbpm_pkg::DEFAULT_AVERAGE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  bbpm_in_if.sink                                sample,
  bbpm_out_if.source                             report,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bbpm_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [bbpm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [bbpm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);
  import bbpm_pkg::*;

  // Arithmetic geometry derived from the ring depth.
  localparam int     L_W         = $clog2(AVERAGE_DEPTH);
  localparam int     SUM_W       = BATT_ADC_W + L_W;
  localparam longint SUM_MAX     = ((longint'(1) << BATT_ADC_W) - 1) * AVERAGE_DEPTH;
  localparam longint ROUND_BIAS  = (longint'(1) << (SCALE_SHIFT - 1)) * AVERAGE_DEPTH;
  localparam longint X_MAX       = SUM_MAX * SCALE_NUM + ROUND_BIAS;
  localparam int     Y_W         = $clog2((X_MAX >> SCALE_SHIFT) + 1);
  localparam int     X_W         = Y_W + SCALE_SHIFT;
  localparam int     RECIP_SHIFT = Y_W + L_W;
  localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + AVERAGE_DEPTH - 1)
                                   / AVERAGE_DEPTH;
  localparam int     RECIP_W     = $clog2(RECIP + 1);
  localparam int     PROD_W      = Y_W + RECIP_W;
  localparam int     Q_W         = PROD_W - RECIP_SHIFT;
  localparam int     BTN_X_W     = BTN_ADC_W + SCALE_NUM_W;
  localparam int     BTN_MV_W    = BTN_X_W - SCALE_SHIFT;

  // Configuration registers.
  logic [MV_W-1:0]    low_battery_mv;
  logic [TICKS_W-1:0] low_battery_ticks;
  logic [TICKS_W-1:0] long_press_ticks;
  logic               shutdown_on_long;
  logic               button_enabled;
  logic               status_enabled;
  logic [MV_W-1:0]    button_threshold_mv;

  // Pipeline handshake.
  logic s1_valid, s2_valid, s3_valid, s4_valid, out_valid;
  logic s1_free, s2_free, s3_free, s4_free, out_free;
  logic s1_move, s2_move, s3_move, s4_move, accept;

  // Stage payloads.
  logic [BATT_ADC_W-1:0] s1_batt;
  logic [BTN_ADC_W-1:0]  s1_btn;
  logic [STAT_ADC_W-1:0] s1_stat;
  logic [SUM_W-1:0]      s2_sum;
  logic                  s2_btn_down;
  logic                  s2_prime;
  charge_t               s2_charge;
  logic [Y_W-1:0]        s3_y;
  logic                  s3_deb, s3_short, s3_long, s3_btn_kill;
  charge_t               s3_charge;
  logic [MV_W-1:0]       s4_mv;
  logic                  s4_deb, s4_short, s4_long, s4_btn_kill;
  charge_t               s4_charge;
  logic [MV_W-1:0]       out_mv;
  logic                  out_deb, out_short, out_long, out_hold;
  charge_t               out_charge;

  // Tick state.
  logic [BATT_ADC_W-1:0] ring [AVERAGE_DEPTH];
  logic [SUM_W-1:0]      ring_sum;
  logic                  primed;
  logic [TICKS_W-1:0]    low_countdown, low_countdown_next;
  logic [TICKS_W-1:0]    press_countdown, press_countdown_next;
  press_mode_t           press_mode, press_mode_next;
  logic                  previous_sample, previous_sample_next;
  logic                  debounced_level, debounced_level_next;
  logic                  hold_power, hold_power_next;

  // Combinational intermediates.
  logic [SUM_W:0]        sum_ext;
  logic [SUM_W-1:0]      sum_next;
  logic [BTN_X_W-1:0]    btn_x;
  logic [X_W-1:0]        batt_x;
  logic [PROD_W-1:0]     recip_prod;
  logic [Q_W-1:0]        quot;
  logic [MV_W-1:0]       mv_sat;
  logic                  btn_short, btn_long, btn_kill;
  logic                  cur, prev0, deb0, deb1, pressed, released;
  press_mode_t           mode0;
  logic [TICKS_W-1:0]    press_cd_dec, low_cd_dec;
  logic                  bat_kill;

  // Configuration port: writes land on the access phase, reads are immediate.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_battery_mv      <= LOW_BATTERY_MV_RST;
      low_battery_ticks   <= LOW_BATTERY_TICKS_RST;
      long_press_ticks    <= LONG_PRESS_TICKS_RST;
      shutdown_on_long    <= 1'b1;
      button_enabled      <= 1'b1;
      status_enabled      <= 1'b1;
      button_threshold_mv <= BUTTON_THRESHOLD_MV_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index_t'(paddr[APB_ADDR_W-1:2]))
        REG_LOW_BATTERY_MV:      low_battery_mv      <= pwdata[MV_W-1:0];
        REG_LOW_BATTERY_TICKS:   low_battery_ticks   <= pwdata[TICKS_W-1:0];
        REG_LONG_PRESS_TICKS:    long_press_ticks    <= pwdata[TICKS_W-1:0];
        REG_SHUTDOWN_ON_LONG:    shutdown_on_long    <= pwdata[0];
        REG_BUTTON_ENABLED:      button_enabled      <= pwdata[0];
        REG_STATUS_ENABLED:      status_enabled      <= pwdata[0];
        REG_BUTTON_THRESHOLD_MV: button_threshold_mv <= pwdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[APB_ADDR_W-1:2]))
      REG_LOW_BATTERY_MV:      prdata = APB_DATA_W'(low_battery_mv);
      REG_LOW_BATTERY_TICKS:   prdata = APB_DATA_W'(low_battery_ticks);
      REG_LONG_PRESS_TICKS:    prdata = APB_DATA_W'(long_press_ticks);
      REG_SHUTDOWN_ON_LONG:    prdata = APB_DATA_W'(shutdown_on_long);
      REG_BUTTON_ENABLED:      prdata = APB_DATA_W'(button_enabled);
      REG_STATUS_ENABLED:      prdata = APB_DATA_W'(status_enabled);
      REG_BUTTON_THRESHOLD_MV: prdata = APB_DATA_W'(button_threshold_mv);
      default:                 prdata = '0;
    endcase
  end

  // Each stage moves forward when the next one is empty or moving itself.
  assign out_free = !out_valid || report.ready;
  assign s4_free  = !s4_valid || out_free;
  assign s3_free  = !s3_valid || s4_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s4_move  = s4_valid && out_free;
  assign s3_move  = s3_valid && s4_free;
  assign s2_move  = s2_valid && s3_free;
  assign s1_move  = s1_valid && s2_free;
  assign accept   = sample.valid && s1_free;
  assign sample.ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= accept  || (s1_valid && !s1_move);
      s2_valid  <= s1_move || (s2_valid && !s2_move);
      s3_valid  <= s2_move || (s3_valid && !s3_move);
      s4_valid  <= s3_move || (s4_valid && !s4_move);
      out_valid <= s4_move || (out_valid && !report.ready);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_batt <= sample.battery_adc_mv;
      s1_btn  <= sample.button_adc_mv;
      s1_stat <= sample.status_adc_mv;
    end
  end

  // Battery ring as a shift line: the oldest sample sits in the last tap.
  // The first item after reset fills every tap with its reading.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      ring[0] <= s1_batt;
      for (int i = 1; i < AVERAGE_DEPTH; i++) begin
        ring[i] <= primed ? ring[i-1] : s1_batt;
      end
    end
  end

  // Running sum update and button threshold compare.
  always_comb begin
    sum_ext = (SUM_W+1)'(ring_sum) + (SUM_W+1)'(s1_batt)
              - (SUM_W+1)'(ring[AVERAGE_DEPTH-1]);
    if (primed) begin
      sum_next = sum_ext[SUM_W-1:0];
    end else begin
      sum_next = SUM_W'(s1_batt) * SUM_W'(AVERAGE_DEPTH);
    end
    btn_x = BTN_X_W'(s1_btn) * BTN_X_W'(SCALE_NUM)
            + BTN_X_W'(longint'(1) << (SCALE_SHIFT - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (s1_move) begin
      primed <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      ring_sum    <= sum_next;
      s2_sum      <= sum_next;
      s2_prime    <= !primed;
      s2_btn_down <= btn_x[BTN_X_W-1:SCALE_SHIFT] >= BTN_MV_W'(button_threshold_mv);
      s2_charge   <= status_enabled ? decode_status(s1_stat) : CHG_IDLE;
    end
  end

  // Debounce and press machine; the first item seeds the button state.
  always_comb begin
    cur          = s2_btn_down;
    press_cd_dec = press_countdown - TICKS_W'(1);
    if (s2_prime) begin
      prev0 = button_enabled && cur;
      deb0  = button_enabled && cur;
      mode0 = (button_enabled && cur) ? MODE_WAIT : MODE_IDLE;
    end else begin
      prev0 = previous_sample;
      deb0  = debounced_level;
      mode0 = press_mode;
    end
    pressed              = 1'b0;
    released             = 1'b0;
    deb1                 = deb0;
    press_mode_next      = mode0;
    previous_sample_next = prev0;
    debounced_level_next = deb0;
    press_countdown_next = press_countdown;
    btn_short            = 1'b0;
    btn_long             = 1'b0;
    btn_kill             = 1'b0;
    if (button_enabled) begin
      pressed              = !deb0 && cur && prev0;
      deb1                 = deb0 || pressed;
      released             = deb1 && !cur && !prev0;
      debounced_level_next = deb1 && !released;
      previous_sample_next = cur;
      case (mode0)
        MODE_WAIT, MODE_LONG: begin
          if (released) begin
            press_mode_next = MODE_IDLE;
          end
        end
        MODE_IDLE: begin
          if (pressed) begin
            press_mode_next      = MODE_SHORT;
            press_countdown_next = long_press_ticks;
          end
        end
        MODE_SHORT: begin
          if (released) begin
            press_mode_next = MODE_IDLE;
            btn_short       = 1'b1;
          end else begin
            press_countdown_next = press_cd_dec;
            if (press_cd_dec == '0) begin
              if (shutdown_on_long) begin
                btn_kill = 1'b1;
              end else begin
                press_mode_next = MODE_LONG;
                btn_long        = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_mode      <= MODE_IDLE;
      previous_sample <= 1'b0;
      debounced_level <= 1'b0;
      press_countdown <= '0;
    end else if (s2_move) begin
      press_mode      <= press_mode_next;
      previous_sample <= previous_sample_next;
      debounced_level <= debounced_level_next;
      press_countdown <= press_countdown_next;
    end
  end

  // Scale the sum by the divider ratio and drop the byte fraction with rounding.
  assign batt_x = X_W'(s2_sum) * X_W'(SCALE_NUM) + X_W'(ROUND_BIAS);

  always_ff @(posedge clk) begin
    if (s2_move) begin
      s3_y        <= batt_x[X_W-1:SCALE_SHIFT];
      s3_deb      <= debounced_level_next;
      s3_short    <= btn_short;
      s3_long     <= btn_long;
      s3_btn_kill <= btn_kill;
      s3_charge   <= s2_charge;
    end
  end

  // Divide by the ring depth with a reciprocal multiply, then saturate.
  always_comb begin
    recip_prod = PROD_W'(s3_y) * PROD_W'(RECIP);
    quot       = recip_prod[PROD_W-1:RECIP_SHIFT];
    if (|quot[Q_W-1:MV_W]) begin
      mv_sat = '1;
    end else begin
      mv_sat = quot[MV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_move) begin
      s4_mv       <= mv_sat;
      s4_deb      <= s3_deb;
      s4_short    <= s3_short;
      s4_long     <= s3_long;
      s4_btn_kill <= s3_btn_kill;
      s4_charge   <= s3_charge;
    end
  end

  // Low battery countdown and the sticky power hold.
  always_comb begin
    low_cd_dec = low_countdown - TICKS_W'(1);
    bat_kill   = 1'b0;
    if (s4_mv < low_battery_mv) begin
      low_countdown_next = low_cd_dec;
      bat_kill           = (low_cd_dec == '0);
    end else begin
      low_countdown_next = low_battery_ticks;
    end
    hold_power_next = hold_power && !bat_kill && !s4_btn_kill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_countdown <= LOW_BATTERY_TICKS_RST;
      hold_power    <= 1'b1;
    end else if (s4_move) begin
      low_countdown <= low_countdown_next;
      hold_power    <= hold_power_next;
    end
  end

  // Report register.
  always_ff @(posedge clk) begin
    if (s4_move) begin
      out_mv     <= s4_mv;
      out_deb    <= s4_deb;
      out_short  <= s4_short;
      out_long   <= s4_long;
      out_charge <= s4_charge;
      out_hold   <= hold_power_next;
    end
  end

  assign report.valid             = out_valid;
  assign report.battery_mv        = out_mv;
  assign report.button_is_down    = out_deb;
  assign report.short_press_pulse = out_short;
  assign report.long_press_pulse  = out_long;
  assign report.charge_status     = out_charge;
  assign report.power_hold        = out_hold;

  // Once power is dropped it never comes back without a reset.
  a_hold_sticky: assert property (@(posedge clk) disable iff (rst)
    !hold_power |=> !hold_power)
    else $error("power hold rose again after shutdown");

  // A reported shutdown must agree with the internal power state.
  a_hold_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hold |-> !hold_power)
    else $error("report shows power off while hold is still set");

  // A short press ends with a release, so the level must read released.
  a_short_released: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_short |-> !out_deb && !out_long)
    else $error("short press reported with the button still down");

  // A long press is reported while the button is still held.
  a_long_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_long |-> out_deb)
    else $error("long press reported with the button released");

endmodule
`default_nettype wire
